// ===== src/q4kdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_pkg
// Shared types, constants and fp helpers for the q4_k x q8_k dot product core.
// ----------------------------------------------------------------------------
package q4kdp_pkg;

  localparam int BEATS_PER_BLOCK = 16;
  localparam int BEAT_W          = $clog2(BEATS_PER_BLOCK);

  localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QUIET_BIT   = 32'h0040_0000;

  typedef struct packed {
    logic        kind;
    logic [15:0] weight_scale_half;
    logic [15:0] weight_min_half;
    logic [63:0] scale_bytes_low;
    logic [31:0] scale_bytes_high;
    logic [31:0] act_scale_bits;
    logic [63:0] weight_bytes;
    logic [63:0] act_even;
    logic [63:0] act_odd;
    logic        last_in_row;
  } in_item_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [3:0] {
    OP_MUL_D,
    OP_MUL_M,
    OP_CVT_I,
    OP_MUL_I,
    OP_ADD_I,
    OP_CVT_M,
    OP_MUL_MS,
    OP_ADD_M,
    OP_ADD_ROW
  } fp_step_t;

  typedef enum logic [1:0] {
    FPU_MUL,
    FPU_ADD,
    FPU_CVT
  } fpu_op_t;

  typedef struct packed {
    logic     hdr_load;
    logic     beat_load;
    logic     beat_sum;
    logic     beat_acc;
    logic     fp_start;
    fp_step_t fp_step;
    logic     sums_clear;
    logic     out_load;
    logic     row_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic beat_end;
    logic row_last;
    logic fp_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [31:0] res;
    logic [23:0] t;
    int          p;
    ex  = h[14:10];
    man = h[9:0];
    p   = 0;
    t   = '0;
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        res = {h[15], 31'd0};
      end else begin
        for (int k = 0; k < 10; k++) begin
          if (man[k]) p = k;
        end
        t   = 24'(man) << (5'(23 - p));
        res = {h[15], 8'(p + 103), t[22:0]};
      end
    end else if (ex == 5'h1F) begin
      res = {h[15], 8'hFF, man, 13'd0};
      if (man != 10'd0) res = res | F32_QUIET_BIT;
    end else begin
      res = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return res;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    n = 6'd48;
    for (int k = 0; k < 48; k++) begin
      if (m[k]) n = 6'(47 - k);
    end
    return n;
  endfunction

endpackage

// ===== src/q4kdp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_in_if
// Input channel: header and data beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface q4kdp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] weight_scale_half;
  logic [15:0] weight_min_half;
  logic [63:0] scale_bytes_low;
  logic [31:0] scale_bytes_high;
  logic [31:0] act_scale_bits;
  logic [63:0] weight_bytes;
  logic [63:0] act_even;
  logic [63:0] act_odd;
  logic        last_in_row;

  modport source (
    output valid, kind, weight_scale_half, weight_min_half, scale_bytes_low,
           scale_bytes_high, act_scale_bits, weight_bytes, act_even, act_odd,
           last_in_row,
    input  ready
  );

  modport sink (
    input  valid, kind, weight_scale_half, weight_min_half, scale_bytes_low,
           scale_bytes_high, act_scale_bits, weight_bytes, act_even, act_odd,
           last_in_row,
    output ready
  );
endinterface

// ===== src/q4kdp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_out_if
// Result channel: fp32 row dot product with valid/ready handshake.
// ----------------------------------------------------------------------------
interface q4kdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_sum_bits;

  modport source (output valid, row_sum_bits, input ready);
  modport sink   (input valid, row_sum_bits, output ready);
endinterface

// ===== src/q4k_q8k_block_dot_product_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4k_q8k_block_dot_product_core
// Q4_K weight row by Q8_K activation dot product, fp32 result per row.
//
//   channel   dir   beat contents
//   in_ch     in    block header or data beat (8 weight bytes, 16 int8 acts)
//   out_ch    out   fp32 bits of the finished row dot product
//
// a header runs two fp multiplies, a data beat a sum and an accumulate step.
// the last beat of a block adds six ops on the shared 3-stage fpu.
// a row end adds one more fpu op plus any wait for the result register.
// synchronous active-low reset clears control, sums and accumulators.
// the result register lets the next beat in while a row result waits.
// ----------------------------------------------------------------------------
module q4k_q8k_block_dot_product_core (
  input  logic        clk,
  input  logic        rst_n,
  q4kdp_in_if.sink    in_ch,
  q4kdp_out_if.source out_ch
);
  import q4kdp_pkg::*;

  in_item_t   in_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign in_item.kind              = in_ch.kind;
  assign in_item.weight_scale_half = in_ch.weight_scale_half;
  assign in_item.weight_min_half   = in_ch.weight_min_half;
  assign in_item.scale_bytes_low   = in_ch.scale_bytes_low;
  assign in_item.scale_bytes_high  = in_ch.scale_bytes_high;
  assign in_item.act_scale_bits    = in_ch.act_scale_bits;
  assign in_item.weight_bytes      = in_ch.weight_bytes;
  assign in_item.act_even          = in_ch.act_even;
  assign in_item.act_odd           = in_ch.act_odd;
  assign in_item.last_in_row       = in_ch.last_in_row;

  q4kdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  q4kdp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_bits  (out_ch.row_sum_bits)
  );

endmodule

// ===== src/q4kdp_fpu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_fpu
// Three stage fp32 multiply / add / int-to-float unit, round to nearest even.
// ----------------------------------------------------------------------------
module q4kdp_fpu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  q4kdp_pkg::fpu_op_t    op,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  input  logic signed [26:0]    ival,
  output logic                  done,
  output logic [31:0]           res
);
  import q4kdp_pkg::*;

  // stage 1: unpack, special cases, raw significand
  logic               s1_c, sp1_c;
  logic signed [11:0] e1_c;
  logic [47:0]        m1_c;
  logic [31:0]        spv1_c;

  logic               v1_r, s1_r, sp1_r;
  logic signed [11:0] e1_r;
  logic [47:0]        m1_r;
  logic [31:0]        spv1_r;

  logic               v2_r, s2_r, sp2_r;
  logic signed [11:0] e2_r;
  logic [47:0]        m2_r;
  logic [31:0]        spv2_r;

  logic               done_r;
  logic [31:0]        res_r;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ea, eb, e_big, e_sml;
  logic [23:0] ma, mb, m_big, m_sml;
  logic        a_big, s_big;
  logic [7:0]  d;
  logic [47:0] aa, bb, bsh;
  logic        lost1;
  logic [26:0] mag;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    a_big  = (a[30:0] >= b[30:0]);
    e_big  = a_big ? ea : eb;
    e_sml  = a_big ? eb : ea;
    m_big  = a_big ? ma : mb;
    m_sml  = a_big ? mb : ma;
    s_big  = a_big ? a[31] : b[31];
    d      = e_big - e_sml;
    aa     = {1'b0, m_big, 23'd0};
    bb     = {1'b0, m_sml, 23'd0};
    bsh    = '0;
    lost1  = 1'b0;
    mag    = '0;
    s1_c   = 1'b0;
    e1_c   = '0;
    m1_c   = '0;
    sp1_c  = 1'b0;
    spv1_c = '0;
    case (op)
      FPU_MUL: begin
        s1_c = a[31] ^ b[31];
        e1_c = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
        m1_c = ma * mb;
        if (a_nan) begin
          sp1_c = 1'b1; spv1_c = a | F32_QUIET_BIT;
        end else if (b_nan) begin
          sp1_c = 1'b1; spv1_c = b | F32_QUIET_BIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
          sp1_c = 1'b1; spv1_c = F32_DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
          sp1_c = 1'b1; spv1_c = {s1_c, 8'hFF, 23'd0};
        end
      end
      FPU_ADD: begin
        if (d >= 8'd48) begin
          bsh   = '0;
          lost1 = |bb;
        end else begin
          bsh   = bb >> d[5:0];
          lost1 = |(bb & ~({48{1'b1}} << d[5:0]));
        end
        bsh[0] = bsh[0] | lost1;
        m1_c   = (a[31] ^ b[31]) ? (aa - bsh) : (aa + bsh);
        e1_c   = $signed({4'd0, e_big}) + 12'sd1;
        s1_c   = (m1_c == 48'd0) ? (a[31] & b[31]) : s_big;
        if (a_nan) begin
          sp1_c = 1'b1; spv1_c = a | F32_QUIET_BIT;
        end else if (b_nan) begin
          sp1_c = 1'b1; spv1_c = b | F32_QUIET_BIT;
        end else if (a_inf && b_inf && (a[31] != b[31])) begin
          sp1_c = 1'b1; spv1_c = F32_DEFAULT_NAN;
        end else if (a_inf) begin
          sp1_c = 1'b1; spv1_c = a;
        end else if (b_inf) begin
          sp1_c = 1'b1; spv1_c = b;
        end
      end
      FPU_CVT: begin
        s1_c = ival[26];
        mag  = ival[26] ? 27'(-ival) : 27'(ival);
        m1_c = {21'd0, mag};
        e1_c = 12'sd174;
      end
      default: begin
        sp1_c  = 1'b1;
        spv1_c = F32_DEFAULT_NAN;
      end
    endcase
  end

  // stage 2: normalise
  logic [5:0] lz;
  assign lz = lzc48(m1_r);

  // stage 3: denormalise if tiny, round, pack
  logic [11:0] sh;
  logic [47:0] ms;
  logic        lost3, g, stk, inc;
  logic [7:0]  ef;
  logic [30:0] body;
  logic [31:0] res_c;

  always_comb begin
    sh    = 12'(12'sd1 - e2_r);
    ms    = m2_r;
    lost3 = 1'b0;
    ef    = e2_r[7:0];
    if (e2_r <= 12'sd0) begin
      ef = 8'd0;
      if (sh >= 12'd48) begin
        ms    = '0;
        lost3 = |m2_r;
      end else begin
        ms    = m2_r >> sh[5:0];
        lost3 = |(m2_r & ~({48{1'b1}} << sh[5:0]));
      end
    end
    g    = ms[23];
    stk  = (|ms[22:0]) | lost3;
    inc  = g & (stk | ms[24]);
    body = {ef, ms[46:24]} + {30'd0, inc};
    if (sp2_r) begin
      res_c = spv2_r;
    end else if (m2_r == 48'd0) begin
      res_c = {s2_r, 31'd0};
    end else if (e2_r >= 12'sd255) begin
      res_c = {s2_r, 8'hFF, 23'd0};
    end else begin
      res_c = {s2_r, body};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    s1_r   <= s1_c;
    e1_r   <= e1_c;
    m1_r   <= m1_c;
    sp1_r  <= sp1_c;
    spv1_r <= spv1_c;
    s2_r   <= s1_r;
    sp2_r  <= sp1_r;
    spv2_r <= spv1_r;
    if (m1_r != 48'd0) begin
      m2_r <= m1_r << lz;
      e2_r <= e1_r - $signed({6'd0, lz});
    end else begin
      m2_r <= m1_r;
      e2_r <= e1_r;
    end
    res_r <= res_c;
  end

  assign done = done_r;
  assign res  = res_r;

  a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 done_r)
    else $error("fpu result not delivered three cycles after start");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !v1_r && !v2_r)
    else $error("fpu started while busy");

endmodule

// ===== src/q4kdp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_datapath
// Sub-scale unpack, lane sums, block integer sums, fp32 row accumulators.
// ----------------------------------------------------------------------------
module q4kdp_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q4kdp_pkg::in_item_t   in_item,
  input  q4kdp_pkg::ctrl_cmd_t  cmd,
  output q4kdp_pkg::dp_status_t status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [31:0]           out_bits
);
  import q4kdp_pkg::*;

  // pair word: {scale even, scale odd, min even, min odd}
  logic [23:0]        pair_r [4];
  logic [23:0]        pair_c [4];
  logic [BEAT_W-1:0]  beat_r;
  logic               last_r;
  logic [15:0]        ws_r, wm_r;
  logic [31:0]        as_r;
  logic [63:0]        w_r, xe_r, xo_r;
  logic signed [14:0] de_r, do_r;
  logic signed [10:0] ae_r, ao_r;
  logic signed [26:0] int_sum_r;
  logic signed [23:0] min_sum_r;
  logic [31:0]        blk_scale_r, blk_min_r, row_dot_r, row_min_r, tmp_r;
  fp_step_t           step_r;
  logic               out_valid_r;
  logic [31:0]        out_bits_r;

  logic [7:0]  q [12];
  logic [5:0]  sc [8];
  logic [5:0]  mn [8];

  always_comb begin
    for (int k = 0; k < 8; k++) q[k] = in_item.scale_bytes_low[8*k +: 8];
    for (int k = 0; k < 4; k++) q[8+k] = in_item.scale_bytes_high[8*k +: 8];
    for (int k = 0; k < 4; k++) begin
      sc[k] = q[k][5:0];
      mn[k] = q[k+4][5:0];
    end
    for (int k = 4; k < 8; k++) begin
      sc[k] = {q[k-4][7:6], q[k+4][3:0]};
      mn[k] = {q[k][7:6], q[k+4][7:4]};
    end
    for (int p = 0; p < 4; p++) begin
      pair_c[p] = {sc[2*p], sc[2*p+1], mn[2*p], mn[2*p+1]};
    end
  end

  // lane sums over the eight bytes of a beat
  logic signed [14:0] de_c, do_c;
  logic signed [10:0] ae_c, ao_c;
  logic signed [7:0]  xe, xo;

  always_comb begin
    de_c = '0;
    do_c = '0;
    ae_c = '0;
    ao_c = '0;
    xe   = '0;
    xo   = '0;
    for (int k = 0; k < 8; k++) begin
      xe   = $signed(xe_r[8*k +: 8]);
      xo   = $signed(xo_r[8*k +: 8]);
      de_c = de_c + 15'($signed({1'b0, w_r[8*k +: 4]}) * xe);
      do_c = do_c + 15'($signed({1'b0, w_r[8*k+4 +: 4]}) * xo);
      ae_c = ae_c + 11'(xe);
      ao_c = ao_c + 11'(xo);
    end
  end

  logic signed [21:0] pe, po;
  logic signed [17:0] qe, qo;
  logic               beat_end;

  assign pe = de_r * $signed({1'b0, pair_r[0][23:18]});
  assign po = do_r * $signed({1'b0, pair_r[0][17:12]});
  assign qe = ae_r * $signed({1'b0, pair_r[0][11:6]});
  assign qo = ao_r * $signed({1'b0, pair_r[0][5:0]});
  assign beat_end = (beat_r == BEAT_W'(BEATS_PER_BLOCK - 1));

  // fp operand selection
  fpu_op_t     fp_op;
  logic [31:0] fp_a, fp_b, fp_res;
  logic        fp_done;
  logic signed [26:0] fp_i;

  always_comb begin
    fp_op = FPU_MUL;
    fp_a  = tmp_r;
    fp_b  = tmp_r;
    fp_i  = int_sum_r;
    unique case (cmd.fp_step)
      OP_MUL_D:   begin fp_a = half_to_single(ws_r); fp_b = as_r; end
      OP_MUL_M:   begin fp_a = half_to_single(wm_r); fp_b = as_r; end
      OP_CVT_I:   begin fp_op = FPU_CVT; fp_i = int_sum_r; end
      OP_MUL_I:   begin fp_a = blk_scale_r; fp_b = tmp_r; end
      OP_ADD_I:   begin fp_op = FPU_ADD; fp_a = row_dot_r; fp_b = tmp_r; end
      OP_CVT_M:   begin fp_op = FPU_CVT; fp_i = 27'(min_sum_r); end
      OP_MUL_MS:  begin fp_a = blk_min_r; fp_b = tmp_r; end
      OP_ADD_M:   begin fp_op = FPU_ADD; fp_a = row_min_r; fp_b = tmp_r; end
      OP_ADD_ROW: begin fp_op = FPU_ADD; fp_a = row_dot_r; fp_b = row_min_r; end
      default:    begin fp_op = FPU_MUL; end
    endcase
  end

  q4kdp_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.fp_start),
    .op    (fp_op),
    .a     (fp_a),
    .b     (fp_b),
    .ival  (fp_i),
    .done  (fp_done),
    .res   (fp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 4; p++) pair_r[p] <= '0;
      beat_r      <= '0;
      last_r      <= 1'b0;
      int_sum_r   <= '0;
      min_sum_r   <= '0;
      blk_scale_r <= '0;
      blk_min_r   <= '0;
      row_dot_r   <= '0;
      row_min_r   <= '0;
      step_r      <= OP_MUL_D;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.hdr_load) begin
        for (int p = 0; p < 4; p++) pair_r[p] <= pair_c[p];
        ws_r      <= in_item.weight_scale_half;
        wm_r      <= in_item.weight_min_half;
        as_r      <= in_item.act_scale_bits;
        beat_r    <= '0;
        int_sum_r <= '0;
        min_sum_r <= '0;
      end
      if (cmd.beat_load) begin
        w_r    <= in_item.weight_bytes;
        xe_r   <= in_item.act_even;
        xo_r   <= in_item.act_odd;
        last_r <= in_item.last_in_row;
      end
      if (cmd.beat_sum) begin
        de_r <= de_c;
        do_r <= do_c;
        ae_r <= ae_c;
        ao_r <= ao_c;
      end
      if (cmd.beat_acc) begin
        int_sum_r <= int_sum_r + 27'(pe) + 27'(po);
        min_sum_r <= min_sum_r + 24'(qe) + 24'(qo);
        beat_r    <= beat_end ? '0 : beat_r + 1'b1;
        // rotate to the next group pair every four beats
        if (beat_r[1:0] == 2'd3) begin
          for (int p = 0; p < 3; p++) pair_r[p] <= pair_r[p+1];
          pair_r[3] <= pair_r[0];
        end
      end
      if (cmd.sums_clear) begin
        int_sum_r <= '0;
        min_sum_r <= '0;
      end
      if (cmd.fp_start) step_r <= cmd.fp_step;
      if (fp_done) begin
        unique case (step_r)
          OP_MUL_D:   blk_scale_r <= fp_res;
          OP_MUL_M:   blk_min_r   <= {~fp_res[31], fp_res[30:0]};
          OP_ADD_I:   row_dot_r   <= fp_res;
          OP_ADD_M:   row_min_r   <= fp_res;
          default:    tmp_r       <= fp_res;
        endcase
      end
      if (cmd.row_clear) begin
        row_dot_r <= '0;
        row_min_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        out_bits_r  <= tmp_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.beat_end = beat_end;
  assign status.row_last = last_r;
  assign status.fp_done  = fp_done;
  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_bits        = out_bits_r;

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");
  a_beat_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.beat_acc && beat_end) |=> (beat_r == '0))
    else $error("beat index did not wrap at block end");

endmodule

// ===== src/q4kdp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_ctrl
// Sequencer: item intake, beat accumulation and the fp fold/row sequence.
// ----------------------------------------------------------------------------
module q4kdp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  q4kdp_pkg::dp_status_t status,
  output q4kdp_pkg::ctrl_cmd_t  cmd
);
  import q4kdp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEAT_SUM,
    ST_BEAT_ACC,
    ST_FP_ISSUE,
    ST_FP_WAIT,
    ST_ROW_OUT
  } state_t;

  state_t   state_r, state_nxt;
  fp_step_t step_r, step_nxt;
  logic     fire;

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd         = '0;
    cmd.fp_step = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (in_kind == KIND_HEADER) begin
            cmd.hdr_load = 1'b1;
            step_nxt     = OP_MUL_D;
            state_nxt    = ST_FP_ISSUE;
          end else begin
            cmd.beat_load = 1'b1;
            state_nxt     = ST_BEAT_SUM;
          end
        end
      end
      ST_BEAT_SUM: begin
        cmd.beat_sum = 1'b1;
        state_nxt    = ST_BEAT_ACC;
      end
      ST_BEAT_ACC: begin
        cmd.beat_acc = 1'b1;
        if (status.beat_end) begin
          step_nxt  = OP_CVT_I;
          state_nxt = ST_FP_ISSUE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FP_ISSUE: begin
        cmd.fp_start = 1'b1;
        state_nxt    = ST_FP_WAIT;
      end
      ST_FP_WAIT: begin
        if (status.fp_done) begin
          case (step_r)
            OP_MUL_M: state_nxt = ST_IDLE;
            OP_ADD_M: begin
              cmd.sums_clear = 1'b1;
              if (status.row_last) begin
                step_nxt  = OP_ADD_ROW;
                state_nxt = ST_FP_ISSUE;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            OP_ADD_ROW: state_nxt = ST_ROW_OUT;
            default: begin
              step_nxt  = fp_step_t'(4'(step_r) + 4'd1);
              state_nxt = ST_FP_ISSUE;
            end
          endcase
        end
      end
      ST_ROW_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.row_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= OP_MUL_D;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== tb/sv/q4kdp_row_dot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4kdp_row_dot_checker
// Watches the input and result channels of the q4_k x q8_k dot product core.
// Every accepted beat is run through a bit-exact predictor with its own fp32
// arithmetic (round to nearest even, subnormals, inf and nan handling). Each
// finished row pushes an expected fp32 sum, and each result beat is compared
// with the oldest one. Mismatches and stray results are counted.
// ----------------------------------------------------------------------------
module q4kdp_row_dot_checker
  import q4kdp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  q4kdp_in_if   in_ch,
  q4kdp_out_if  out_ch,
  output int    mismatches,
  output int    pending
);

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  logic [5:0]  sc_tab [8];
  logic [5:0]  mn_tab [8];
  int          beat_no;
  logic [31:0] d_scale;
  logic [31:0] m_scale;
  int          int_sum;
  int          min_sum;
  logic [31:0] dot_acc;
  logic [31:0] min_acc;
  logic [31:0] row_sums [$];

  function automatic logic [31:0] f32_round(input logic s, input logic [127:0] sig,
                                            input int e2);
    int           n;
    int           sh;
    int           ex;
    logic [127:0] m;
    logic [127:0] rem;
    logic [127:0] half;
    if (sig == '0) return {s, 31'd0};
    n = 0;
    for (int k = 0; k < 128; k++) if (sig[k]) n = k;
    sh = n - 23;
    if (-149 - e2 > sh) sh = -149 - e2;
    if (sh >= 120) begin
      m = '0;
    end else if (sh > 0) begin
      m    = sig >> sh;
      rem  = sig & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m = m + 128'd1;
    end else begin
      m = sig << (-sh);
    end
    ex = e2 + sh;
    if (m[24]) begin
      m  = m >> 1;
      ex = ex + 1;
    end
    if (m[23]) begin
      if (ex + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(ex + 150), m[22:0]};
    end
    return {s, 8'd0, m[22:0]};
  endfunction

  function automatic logic [23:0] f32_sig(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  function automatic int f32_exp(input logic [31:0] a);
    return ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != '0;
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == '0;
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == '0;
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | F32_QUIET_BIT;
    if (is_nan(b)) return b | F32_QUIET_BIT;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return F32_DEFAULT_NAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    return f32_round(s, 128'(f32_sig(a)) * 128'(f32_sig(b)), f32_exp(a) + f32_exp(b));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  x;
    logic [31:0]  y;
    int           d;
    int           e;
    logic [127:0] big;
    logic [127:0] lit;
    if (is_nan(a)) return a | F32_QUIET_BIT;
    if (is_nan(b)) return b | F32_QUIET_BIT;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return F32_DEFAULT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    x = a;
    y = b;
    if (f32_exp(a) < f32_exp(b)) begin
      x = b;
      y = a;
    end
    d = f32_exp(x) - f32_exp(y);
    if (d > 50) begin
      big = 128'(f32_sig(x)) << 50;
      lit = 128'd1;
      e   = f32_exp(x) - 50;
    end else begin
      big = 128'(f32_sig(x)) << d;
      lit = 128'(f32_sig(y));
      e   = f32_exp(y);
    end
    if (x[31] == y[31]) return f32_round(x[31], big + lit, e);
    if (big > lit) return f32_round(x[31], big - lit, e);
    if (lit > big) return f32_round(y[31], lit - big, e);
    return 32'd0;
  endfunction

  function automatic logic [31:0] int_to_f32(input int v);
    return f32_round(v < 0, 128'((v < 0) ? -v : v), 0);
  endfunction

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [31:0] r;
    if (h[14:10] == 5'd0) return f32_round(h[15], 128'(h[9:0]), -24);
    if (h[14:10] == 5'h1F) begin
      r = {h[15], 8'hFF, h[9:0], 13'd0};
      if (h[9:0] != '0) r = r | F32_QUIET_BIT;
      return r;
    end
    return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic int lane_s8(input logic [63:0] v, input int k);
    return int'($signed(v[8*k +: 8]));
  endfunction

  task automatic predict_beat(input in_item_t it);
    logic [7:0] q [12];
    int         pr;
    int         de;
    int         dd;
    int         ae;
    int         ao;
    int         wb;
    if (it.kind == KIND_HEADER) begin
      for (int k = 0; k < 8; k++) q[k] = it.scale_bytes_low[8*k +: 8];
      for (int k = 0; k < 4; k++) q[8+k] = it.scale_bytes_high[8*k +: 8];
      for (int k = 0; k < 4; k++) begin
        sc_tab[k] = q[k][5:0];
        mn_tab[k] = q[k+4][5:0];
      end
      for (int k = 4; k < 8; k++) begin
        sc_tab[k] = {q[k-4][7:6], q[k+4][3:0]};
        mn_tab[k] = {q[k][7:6], q[k+4][7:4]};
      end
      d_scale = f32_mul(half_to_f32(it.weight_scale_half), it.act_scale_bits);
      m_scale = f32_mul(half_to_f32(it.weight_min_half), it.act_scale_bits) ^ SIGN_BIT;
      beat_no = 0;
      int_sum = 0;
      min_sum = 0;
    end else begin
      pr = (beat_no >> 2) & 3;
      de = 0;
      dd = 0;
      ae = 0;
      ao = 0;
      for (int k = 0; k < 8; k++) begin
        wb = int'(it.weight_bytes[8*k +: 8]);
        de += (wb & 15) * lane_s8(it.act_even, k);
        dd += (wb >> 4) * lane_s8(it.act_odd, k);
        ae += lane_s8(it.act_even, k);
        ao += lane_s8(it.act_odd, k);
      end
      int_sum += de * int'(sc_tab[2*pr]) + dd * int'(sc_tab[2*pr+1]);
      min_sum += ae * int'(mn_tab[2*pr]) + ao * int'(mn_tab[2*pr+1]);
      if (beat_no + 1 < BEATS_PER_BLOCK) begin
        beat_no++;
      end else begin
        beat_no = 0;
        dot_acc = f32_add(dot_acc, f32_mul(d_scale, int_to_f32(int_sum)));
        min_acc = f32_add(min_acc, f32_mul(m_scale, int_to_f32(min_sum)));
        int_sum = 0;
        min_sum = 0;
        if (it.last_in_row) begin
          row_sums.push_back(f32_add(dot_acc, min_acc));
          dot_acc = '0;
          min_acc = '0;
        end
      end
    end
  endtask

  in_item_t   seen;
  logic [31:0] want;

  initial begin
    mismatches = 0;
    pending    = 0;
    for (int k = 0; k < 8; k++) begin
      sc_tab[k] = '0;
      mn_tab[k] = '0;
    end
    beat_no = 0;
    d_scale = '0;
    m_scale = '0;
    int_sum = 0;
    min_sum = 0;
    dot_acc = '0;
    min_acc = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen = '{kind: in_ch.kind, weight_scale_half: in_ch.weight_scale_half,
                 weight_min_half: in_ch.weight_min_half,
                 scale_bytes_low: in_ch.scale_bytes_low,
                 scale_bytes_high: in_ch.scale_bytes_high,
                 act_scale_bits: in_ch.act_scale_bits, weight_bytes: in_ch.weight_bytes,
                 act_even: in_ch.act_even, act_odd: in_ch.act_odd,
                 last_in_row: in_ch.last_in_row};
        predict_beat(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (row_sums.size() == 0) begin
          $error("row_sum_bits: expected none, actual %h", out_ch.row_sum_bits);
          mismatches++;
        end else begin
          want = row_sums.pop_front();
          if (out_ch.row_sum_bits !== want) begin
            $error("row_sum_bits: expected %h, actual %h", want, out_ch.row_sum_bits);
            mismatches++;
          end
        end
      end
      pending = row_sums.size();
    end
  end

endmodule

// ===== tb/sv/tb_q4k_q8k_block_dot_product_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q4k_q8k_block_dot_product_core
// Drives rows of q4_k blocks (headers and data beats) into the dot product
// core with random gaps and result back-pressure, and gives the verdict from
// the checker's mismatch and pending counts. Directed blocks cover extreme
// fields and fp16 special values; the random part mixes full rows with dropped
// headers, aborted blocks and stray row-end marks.
// ----------------------------------------------------------------------------
module tb_q4k_q8k_block_dot_product_core;
  import q4kdp_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   n_items;
  int   cycles;
  int   mismatches;
  int   pending;

  q4kdp_in_if  in_ch ();
  q4kdp_out_if out_ch ();

  q4k_q8k_block_dot_product_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  q4kdp_row_dot_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rand_half();
    if ($urandom_range(9) < 7) return {1'($urandom()), 5'($urandom_range(20, 8)),
                                       10'($urandom())};
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] rand_act_scale();
    if ($urandom_range(9) < 8) return {1'($urandom()), 8'($urandom_range(130, 100)),
                                       23'($urandom())};
    return $urandom();
  endfunction

  function automatic in_item_t make_header();
    in_item_t it;
    it                   = '{default: '0};
    it.kind              = KIND_HEADER;
    it.weight_scale_half = rand_half();
    it.weight_min_half   = rand_half();
    it.scale_bytes_low   = rand64();
    it.scale_bytes_high  = $urandom();
    it.act_scale_bits    = rand_act_scale();
    it.weight_bytes      = rand64();
    it.act_even          = rand64();
    it.act_odd           = rand64();
    it.last_in_row       = 1'($urandom());
    return it;
  endfunction

  function automatic in_item_t make_data(input logic last);
    in_item_t it;
    it              = make_header();
    it.kind         = KIND_DATA;
    it.last_in_row  = last;
    if ($urandom_range(9) == 0) begin
      it.weight_bytes = '1;
      it.act_even     = $urandom_range(1) ? {8{8'h80}} : {8{8'h7F}};
      it.act_odd      = $urandom_range(1) ? {8{8'h80}} : {8{8'h7F}};
    end
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    logic ok;
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= it.kind;
    in_ch.weight_scale_half <= it.weight_scale_half;
    in_ch.weight_min_half   <= it.weight_min_half;
    in_ch.scale_bytes_low   <= it.scale_bytes_low;
    in_ch.scale_bytes_high  <= it.scale_bytes_high;
    in_ch.act_scale_bits    <= it.act_scale_bits;
    in_ch.weight_bytes      <= it.weight_bytes;
    in_ch.act_even          <= it.act_even;
    in_ch.act_odd           <= it.act_odd;
    in_ch.last_in_row       <= it.last_in_row;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end
    n_items++;
    if (n_items == ITEM_TARGET / 3) begin
      in_idle_pct  = 87;
      out_idle_pct = 15;
    end else if (n_items == 2 * ITEM_TARGET / 3) begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
  endtask

  task automatic send_block(input logic with_header, input logic row_end);
    if (with_header) send_beat(make_header());
    for (int b = 0; b < BEATS_PER_BLOCK; b++) begin
      if (b == BEATS_PER_BLOCK - 1) send_beat(make_data(row_end));
      else send_beat(make_data($urandom_range(9) == 0));
    end
  endtask

  in_item_t it;
  int       nblk;

  initial begin
    rst_n        = 1'b0;
    in_idle_pct  = 15;
    out_idle_pct = 87;
    n_items      = 0;
    cycles       = 0;
    out_ch.ready = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_HEADER;
    in_ch.weight_scale_half = '0;
    in_ch.weight_min_half   = '0;
    in_ch.scale_bytes_low   = '0;
    in_ch.scale_bytes_high  = '0;
    in_ch.act_scale_bits    = '0;
    in_ch.weight_bytes      = '0;
    in_ch.act_even          = '0;
    in_ch.act_odd           = '0;
    in_ch.last_in_row       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme block: max scales, subnormal min, full-scale weights and acts
    it                   = make_header();
    it.weight_scale_half = 16'h7BFF;
    it.weight_min_half   = 16'h0001;
    it.scale_bytes_low   = '1;
    it.scale_bytes_high  = '1;
    it.act_scale_bits    = 32'h3F80_0000;
    send_beat(it);
    for (int b = 0; b < BEATS_PER_BLOCK; b++) begin
      it              = make_data(b == 5 || b == BEATS_PER_BLOCK - 1);
      it.weight_bytes = '1;
      it.act_even     = {8{8'h80}};
      it.act_odd      = {8{8'h7F}};
      send_beat(it);
    end
    // inf header, partial block, then nan header with negative zero min
    it                   = make_header();
    it.weight_scale_half = 16'h7C00;
    it.weight_min_half   = 16'h0000;
    send_beat(it);
    send_beat(make_data(1'b1));
    send_beat(make_data(1'b0));
    it                   = make_header();
    it.weight_scale_half = 16'h7D55;
    it.weight_min_half   = 16'h8000;
    send_beat(it);
    send_block(1'b0, 1'b1);

    while (n_items < ITEM_TARGET) begin
      nblk = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
      for (int k = 0; k < nblk; k++) begin
        if ($urandom_range(19) == 0) begin
          send_beat(make_header());
          repeat ($urandom_range(BEATS_PER_BLOCK - 1, 1)) send_beat(make_data(1'($urandom())));
        end
        send_block($urandom_range(9) != 0, k == nblk - 1);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
